/* src/ldbrt_pkg.sv */
// Shared types for the depth-bin range table.
`default_nettype none
package ldbrt_pkg;
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RANK,
    ST_RANK_WAIT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_EMIT
  } state_t;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned Q_ONE = 16384;
  localparam int unsigned BIN_OUT_W = 4;
  localparam int unsigned FIRST_OUT_W = 9;
  localparam int unsigned FINAL_OUT_W = 8;
endpackage
`default_nettype wire

/* src/light_depth_bin_range_table_core.sv */
// Depth-bin range table: light store, rank sort by counting, per-bin range scan.
// Load: one light per cycle, busy low. After the last light, ranking takes each kept
// light in turn (key read, a sweep over all kept lights, one write to the sorted store),
// then each of NUM_BINS bins takes a sorted-store sweep (if any light is kept) and an output beat.
// Results appear as single-cycle out_valid beats; the receiver cannot stall.
// Synchronous active-low reset clears state and light count only; the stores are not cleared.
`default_nettype none
module light_depth_bin_range_table_core #(
  parameter int unsigned MAX_LIGHTS = 256,
  parameter int unsigned NUM_BINS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [ldbrt_pkg::DEPTH_W-1:0]  in_center_depth,
  input  wire logic signed [ldbrt_pkg::DEPTH_W-1:0]  in_near_depth,
  input  wire logic signed [ldbrt_pkg::DEPTH_W-1:0]  in_far_depth,
  input  wire logic                                  in_light_last,
  output logic                                       out_valid,
  output logic [ldbrt_pkg::BIN_OUT_W-1:0]            out_bin_number,
  output logic [ldbrt_pkg::FIRST_OUT_W-1:0]          out_first_light,
  output logic [ldbrt_pkg::FINAL_OUT_W-1:0]          out_final_light,
  output logic                                       out_result_last
);
  localparam int unsigned AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned CW = $clog2(MAX_LIGHTS + 1);
  localparam int unsigned BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned NB_W = $clog2(NUM_BINS + 1);
  localparam int unsigned DW = ldbrt_pkg::DEPTH_W;
  localparam int unsigned SW = DW + NB_W + 1;
  localparam int unsigned PW = (CW > ldbrt_pkg::FIRST_OUT_W) ? CW + 1
                                                             : ldbrt_pkg::FIRST_OUT_W + 1;
  localparam logic [PW-1:0] EMPTY_FIRST = PW'(MAX_LIGHTS + 1);

  // Light store in arrival order, and rank-ordered store.
  logic [3*DW-1:0] store_mem [MAX_LIGHTS];
  logic [3*DW-1:0] sort_mem  [MAX_LIGHTS];
  logic [3*DW-1:0] store_rd_r;
  logic [3*DW-1:0] sort_rd_r;
  logic            store_we;
  logic [AW-1:0]   store_wa;
  logic [3*DW-1:0] store_wd;
  logic [AW-1:0]   store_ra;
  logic            sort_we;
  logic [AW-1:0]   sort_wa;
  logic [AW-1:0]   sort_ra;

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    store_rd_r <= store_mem[store_ra];
  end

  always_ff @(posedge clk) begin
    if (sort_we) begin
      sort_mem[sort_wa] <= store_rd_r;
    end
    sort_rd_r <= sort_mem[sort_ra];
  end

  ldbrt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] rank_r, rank_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  logic [BW-1:0] bin_r, bin_nxt;
  logic [PW-1:0] first_r, first_nxt;
  logic [CW-1:0] final_r, final_nxt;
  logic emit_last;

  // Bin membership: b*Q <= d*NB <= (b+1)*Q.
  function automatic logic in_bin(input logic signed [DW-1:0] d, input logic [BW-1:0] b);
    logic signed [SW+15:0] sc;
    logic signed [SW+15:0] lo;
    logic signed [SW+15:0] hi;
    sc = (SW+16)'(d) * $signed((SW+16)'(NUM_BINS));
    lo = $signed((SW+16)'(b)) * $signed((SW+16)'(ldbrt_pkg::Q_ONE));
    hi = lo + $signed((SW+16)'(ldbrt_pkg::Q_ONE));
    return (sc >= lo) && (sc <= hi);
  endfunction

  logic signed [DW-1:0] rd_ctr;
  logic signed [DW-1:0] s_ctr, s_lo, s_hi;
  logic                 hit;
  assign rd_ctr = store_rd_r[3*DW-1:2*DW];
  assign s_ctr  = sort_rd_r[3*DW-1:2*DW];
  assign s_lo   = sort_rd_r[2*DW-1:DW];
  assign s_hi   = sort_rd_r[DW-1:0];
  assign hit    = in_bin(s_ctr, bin_r) || in_bin(s_lo, bin_r) || in_bin(s_hi, bin_r);
  assign emit_last = (32'(bin_r) == NUM_BINS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldbrt_pkg::ST_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    rank_r  <= rank_nxt;
    key_r   <= key_nxt;
    bin_r   <= bin_nxt;
    first_r <= first_nxt;
    final_r <= final_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    bin_nxt   = bin_r;
    first_nxt = first_r;
    final_nxt = final_r;
    store_we  = 1'b0;
    store_wa  = count_r[AW-1:0];
    store_wd  = {in_center_depth, in_near_depth, in_far_depth};
    store_ra  = j_r[AW-1:0];
    sort_we   = 1'b0;
    sort_wa   = rank_r[AW-1:0];
    sort_ra   = j_r[AW-1:0];
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ldbrt_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          if (32'(count_r) < MAX_LIGHTS) begin
            store_we  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          if (in_light_last) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ldbrt_pkg::ST_RANK;
          end
        end
      end
      // Read light i to take its key, then sweep j counting lights before it.
      ldbrt_pkg::ST_RANK: begin
        store_ra = i_r[AW-1:0];
        if (i_r == count_r) begin
          j_nxt     = '0;
          bin_nxt   = '0;
          first_nxt = EMPTY_FIRST;
          final_nxt = '0;
          state_nxt = (count_r == '0) ? ldbrt_pkg::ST_EMIT : ldbrt_pkg::ST_SCAN;
        end else begin
          j_nxt     = '0;
          rank_nxt  = '0;
          state_nxt = ldbrt_pkg::ST_RANK_WAIT;
        end
      end
      ldbrt_pkg::ST_RANK_WAIT: begin
        // On entry (j zero): latch key; on later steps: compare light j-1.
        store_ra = j_r[AW-1:0];
        if (j_r == '0) begin
          key_nxt = rd_ctr;
        end
        j_nxt = j_r + CW'(1);
        if (j_r != '0) begin
          if ((rd_ctr < key_r) || ((rd_ctr == key_r) && (j_r - CW'(1) < i_r))) begin
            rank_nxt = rank_r + CW'(1);
          end
        end
        if (j_r == count_r) begin
          store_ra  = i_r[AW-1:0];
          state_nxt = ldbrt_pkg::ST_SCAN_WAIT;
        end
      end
      ldbrt_pkg::ST_SCAN_WAIT: begin
        // The store output holds light i, read again on the last sweep step; write it at its rank.
        store_ra = i_r[AW-1:0];
        if (j_r == count_r + CW'(1)) begin
          sort_we   = 1'b1;
          i_nxt     = i_r + CW'(1);
          state_nxt = ldbrt_pkg::ST_RANK;
        end else begin
          j_nxt = count_r + CW'(1);
        end
      end
      // Sweep sorted positions for the current bin.
      ldbrt_pkg::ST_SCAN: begin
        sort_ra = j_r[AW-1:0];
        j_nxt   = j_r + CW'(1);
        if (j_r != '0 && hit) begin
          if (first_r == EMPTY_FIRST) begin
            first_nxt = PW'(j_r - CW'(1));
          end
          final_nxt = j_r - CW'(1);
        end
        if (j_r == count_r) begin
          state_nxt = ldbrt_pkg::ST_EMIT;
        end
      end
      ldbrt_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        j_nxt     = '0;
        first_nxt = EMPTY_FIRST;
        final_nxt = '0;
        if (emit_last) begin
          count_nxt = '0;
          state_nxt = ldbrt_pkg::ST_LOAD;
        end else begin
          bin_nxt   = bin_r + BW'(1);
          state_nxt = (count_r == '0) ? ldbrt_pkg::ST_EMIT : ldbrt_pkg::ST_SCAN;
        end
      end
      default: begin
        state_nxt = ldbrt_pkg::ST_LOAD;
      end
    endcase
  end

  // Key latch happens on entry to RANK_WAIT, when the key read lands.
  assign out_bin_number  = ldbrt_pkg::BIN_OUT_W'(bin_r);
  assign out_first_light = first_r[ldbrt_pkg::FIRST_OUT_W-1:0];
  assign out_final_light = ldbrt_pkg::FINAL_OUT_W'(final_r);
  assign out_result_last = emit_last;
endmodule
`default_nettype wire
